/* sv/stes_pkg.sv */
// Shared constants, codes and types of the sample-timed event scheduler.
`default_nettype none
package stes_pkg;

  localparam int EVENT_SLOTS = 32;
  localparam int EVENT_CAP   = EVENT_SLOTS;
  localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W       = $clog2(EVENT_SLOTS + 1);

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;
  localparam logic [1:0] KIND_REARM   = 2'd3;

  localparam logic [1:0] RES_STATUS  = 2'd0;
  localparam logic [1:0] RES_SEGMENT = 2'd1;
  localparam logic [1:0] RES_FIRED   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_WAITING  = 2'd3;

  typedef struct packed {
    logic              we_dl;
    logic              we_id;
    logic [SLOT_W-1:0] addr;
    logic [63:0]       dl;
    logic [15:0]       id;
  } tbl_wr_t;

endpackage
`default_nettype wire

/* sv/stes_table.sv */
// Event table: deadline and key memories with one read and one write port.
`default_nettype none
module stes_table (
  input  wire logic                        clk,
  input  wire logic [stes_pkg::SLOT_W-1:0] rd_addr,
  input  wire stes_pkg::tbl_wr_t           wr,
  output logic [63:0]                      rd_dl,
  output logic [15:0]                      rd_id
);

  logic [63:0] mem_dl [stes_pkg::EVENT_SLOTS];
  logic [15:0] mem_id [stes_pkg::EVENT_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we_dl) begin
      mem_dl[wr.addr] <= wr.dl;
    end
    if (wr.we_id) begin
      mem_id[wr.addr] <= wr.id;
    end
    rd_dl <= mem_dl[rd_addr];
    rd_id <= mem_id[rd_addr];
  end

endmodule
`default_nettype wire

/* sv/sample_timed_event_scheduler_top.sv */
// Sample-timed event scheduler: control sequencer around the event table.
//
// Input channel (in_valid/in_ready) takes one command item: add, remove,
// advance or rearm. Result channel (out_valid/out_ready) returns one or two
// items per command; out_last marks the final one.
// Remove scans the key memory one entry a cycle and then shifts the tail down
// one entry a cycle, then returns its status. Advance scans all stored
// deadlines through the single read port; its segment, if any, comes before
// its fired result, and only a status comes when no samples are asked for.
// A rearm first makes its deadline update, or the key scan and shift when it
// removes its event.
// One command is in work at a time; in_ready is high only between commands.
// The result register lets the next command be taken while the last result
// still waits; a stalled receiver holds the sequencer at its next result.
// After reset the table is empty, the tick is zero and no event is pending.
// Table memories are not cleared; only entries below the count are read.
`default_nettype none
module sample_timed_event_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_event_key,
  input  wire logic [31:0] in_delay,
  input  wire logic [15:0] in_sample_count,
  input  wire logic [31:0] in_repeat_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_type,
  output logic [15:0]      out_segment_length,
  output logic [15:0]      out_fired_key,
  output logic [1:0]       out_status,
  output logic [62:0]      out_tick_now,
  output logic             out_last
);

  localparam int SW = stes_pkg::SLOT_W;
  localparam int CW = stes_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_STATUS, S_REARM_RD, S_REARM_WR, S_ID_RD, S_ID_WAIT, S_KSCAN,
    S_DROP, S_RUN_START, S_MSCAN, S_RUN_CALC, S_RUN_DEC, S_RUN_SEG, S_RUN_FIRE
  } state_t;

  state_t       state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [62:0]  tick_r, tick_nxt;
  logic [15:0]  sl_r, sl_nxt;
  logic         await_r, await_nxt;
  logic [SW-1:0] fslot_r, fslot_nxt;
  logic         rearm_r, rearm_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] q_r, q_nxt;
  logic         v_r, v_nxt;
  logic         found_r, found_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [15:0]  key_r, key_nxt;
  logic [31:0]  rep_r, rep_nxt;
  logic [63:0]  best_dl_r, best_dl_nxt;
  logic [SW-1:0] best_slot_r, best_slot_nxt;
  logic [15:0]  best_id_r, best_id_nxt;
  logic         diff_small_r, diff_small_nxt;
  logic [15:0]  diff16_r, diff16_nxt;
  logic         due_r, due_nxt;
  logic         bd63_r, bd63_nxt;
  logic [15:0]  ns_r, ns_nxt;
  logic         fire_r, fire_nxt;
  logic [1:0]   status_r, status_nxt;
  logic [1:0]   out_type_r, out_type_nxt;
  logic [15:0]  out_seg_r, out_seg_nxt;
  logic [15:0]  out_key_r, out_key_nxt;
  logic [1:0]   out_st_r, out_st_nxt;
  logic [62:0]  out_tick_r, out_tick_nxt;
  logic         out_last_r, out_last_nxt;

  logic [SW-1:0]     rd_addr;
  stes_pkg::tbl_wr_t wr;
  logic [63:0]       rd_dl;
  logic [15:0]       rd_id;

  logic          issue;
  logic          out_free;
  logic [64:0]   diff;
  logic [63:0]   rearm_sum;
  logic [64:0]   rearm_wide;
  logic [62:0]   tick_sum;
  logic          le_sl;
  logic [CW-1:0] drop_addr;

  stes_table u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_dl   (rd_dl),
    .rd_id   (rd_id)
  );

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_type    = out_type_r;
  assign out_segment_length = out_seg_r;
  assign out_fired_key      = out_key_r;
  assign out_status         = out_st_r;
  assign out_tick_now       = out_tick_r;
  assign out_last           = out_last_r;

  assign out_free   = !out_valid_r || out_ready;
  assign diff       = {1'b0, best_dl_r} - {2'b00, tick_r};
  assign rearm_wide = {1'b0, rd_dl} + {33'd0, rep_r};
  assign rearm_sum  = rearm_wide[64] ? {64{1'b1}} : rearm_wide[63:0];
  assign tick_sum   = tick_r + {47'd0, ns_r};
  assign le_sl      = diff_small_r && (diff16_r <= sl_r);
  assign drop_addr  = q_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tick_nxt      = tick_r;
    sl_nxt        = sl_r;
    await_nxt     = await_r;
    fslot_nxt     = fslot_r;
    rearm_nxt     = rearm_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    v_nxt         = v_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    key_nxt       = key_r;
    rep_nxt       = rep_r;
    best_dl_nxt   = best_dl_r;
    best_slot_nxt = best_slot_r;
    best_id_nxt   = best_id_r;
    diff_small_nxt = diff_small_r;
    diff16_nxt    = diff16_r;
    due_nxt       = due_r;
    bd63_nxt      = bd63_r;
    ns_nxt        = ns_r;
    fire_nxt      = fire_r;
    status_nxt    = status_r;
    out_type_nxt  = out_type_r;
    out_seg_nxt   = out_seg_r;
    out_key_nxt   = out_key_r;
    out_st_nxt    = out_st_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;
    wr            = '0;
    rd_addr       = p_r[SW-1:0];
    issue         = (p_r < count_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_STATUS;
          case (in_kind)
            stes_pkg::KIND_ADD: begin
              if (count_r >= CW'(stes_pkg::EVENT_CAP)) begin
                status_nxt = stes_pkg::ST_FULL;
              end else begin
                wr.we_dl   = 1'b1;
                wr.we_id   = 1'b1;
                wr.addr    = count_r[SW-1:0];
                wr.dl      = {1'b0, tick_r} + {32'd0, in_delay};
                wr.id      = in_event_key;
                count_nxt  = count_r + CW'(1);
                status_nxt = stes_pkg::ST_OK;
              end
            end
            stes_pkg::KIND_REMOVE: begin
              if (await_r) begin
                status_nxt = stes_pkg::ST_WAITING;
              end else begin
                key_nxt   = in_event_key;
                rearm_nxt = 1'b0;
                p_nxt     = '0;
                v_nxt     = 1'b0;
                state_nxt = S_KSCAN;
              end
            end
            stes_pkg::KIND_ADVANCE: begin
              if (await_r) begin
                status_nxt = stes_pkg::ST_WAITING;
              end else begin
                sl_nxt    = in_sample_count;
                state_nxt = S_RUN_START;
              end
            end
            default: begin
              if (!await_r) begin
                status_nxt = stes_pkg::ST_WAITING;
              end else begin
                await_nxt = 1'b0;
                rearm_nxt = 1'b1;
                rep_nxt   = in_repeat_req;
                if ({{(CW-SW){1'b0}}, fslot_r} < count_r) begin
                  state_nxt = (in_repeat_req != 32'd0) ? S_REARM_RD : S_ID_RD;
                end else begin
                  state_nxt = S_RUN_START;
                end
              end
            end
          endcase
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = stes_pkg::RES_STATUS;
          out_seg_nxt   = '0;
          out_key_nxt   = '0;
          out_st_nxt    = status_r;
          out_tick_nxt  = tick_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REARM_RD: begin
        rd_addr   = fslot_r;
        state_nxt = S_REARM_WR;
      end
      S_REARM_WR: begin
        wr.we_dl  = 1'b1;
        wr.addr   = fslot_r;
        wr.dl     = rearm_sum;
        state_nxt = S_RUN_START;
      end
      S_ID_RD: begin
        rd_addr   = fslot_r;
        state_nxt = S_ID_WAIT;
      end
      S_ID_WAIT: begin
        key_nxt   = rd_id;
        p_nxt     = '0;
        v_nxt     = 1'b0;
        state_nxt = S_KSCAN;
      end
      S_KSCAN: begin
        if (v_r && rd_id == key_r) begin
          p_nxt     = q_r + CW'(1);
          v_nxt     = 1'b0;
          state_nxt = S_DROP;
        end else if (!issue && !v_r) begin
          status_nxt = stes_pkg::ST_NOTFOUND;
          state_nxt  = rearm_r ? S_RUN_START : S_STATUS;
        end else begin
          p_nxt = issue ? p_r + CW'(1) : p_r;
          v_nxt = issue;
          q_nxt = p_r;
        end
      end
      S_DROP: begin
        if (v_r) begin
          wr.we_dl = 1'b1;
          wr.we_id = 1'b1;
          wr.addr  = drop_addr[SW-1:0];
          wr.dl    = rd_dl;
          wr.id    = rd_id;
        end
        if (!issue && !v_r) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = stes_pkg::ST_OK;
          state_nxt  = rearm_r ? S_RUN_START : S_STATUS;
        end else begin
          p_nxt = issue ? p_r + CW'(1) : p_r;
          v_nxt = issue;
          q_nxt = p_r;
        end
      end
      S_RUN_START: begin
        if (sl_r == 16'd0) begin
          status_nxt = stes_pkg::ST_OK;
          state_nxt  = S_STATUS;
        end else begin
          p_nxt     = '0;
          v_nxt     = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (v_r && (!found_r || rd_dl < best_dl_r)) begin
          best_dl_nxt   = rd_dl;
          best_id_nxt   = rd_id;
          best_slot_nxt = q_r[SW-1:0];
          found_nxt     = 1'b1;
        end
        if (!issue && !v_r) begin
          state_nxt = S_RUN_CALC;
        end else begin
          p_nxt = issue ? p_r + CW'(1) : p_r;
          v_nxt = issue;
          q_nxt = p_r;
        end
      end
      S_RUN_CALC: begin
        due_nxt        = diff[64] || (diff[63:0] == 64'd0);
        diff_small_nxt = (diff[63:16] == 48'd0);
        diff16_nxt     = diff[15:0];
        bd63_nxt       = best_dl_r[63];
        state_nxt      = S_RUN_DEC;
      end
      S_RUN_DEC: begin
        if (!found_r) begin
          ns_nxt   = sl_r;
          fire_nxt = 1'b0;
        end else if (due_r) begin
          ns_nxt   = '0;
          fire_nxt = 1'b1;
        end else begin
          ns_nxt   = le_sl ? diff16_r : sl_r;
          fire_nxt = le_sl && !bd63_r;
        end
        state_nxt = S_RUN_SEG;
      end
      S_RUN_SEG: begin
        if (ns_r == 16'd0) begin
          state_nxt = S_RUN_FIRE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = stes_pkg::RES_SEGMENT;
          out_seg_nxt   = ns_r;
          out_key_nxt   = '0;
          out_st_nxt    = stes_pkg::ST_OK;
          out_tick_nxt  = tick_sum;
          out_last_nxt  = !fire_r;
          tick_nxt      = tick_sum;
          sl_nxt        = sl_r - ns_r;
          state_nxt     = fire_r ? S_RUN_FIRE : S_IDLE;
        end
      end
      S_RUN_FIRE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_type_nxt  = stes_pkg::RES_FIRED;
          out_seg_nxt   = '0;
          out_key_nxt   = best_id_r;
          out_st_nxt    = stes_pkg::ST_OK;
          out_tick_nxt  = tick_r;
          out_last_nxt  = 1'b1;
          await_nxt     = 1'b1;
          fslot_nxt     = best_slot_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_r      <= '0;
      sl_r        <= '0;
      await_r     <= 1'b0;
      fslot_r     <= '0;
      rearm_r     <= 1'b0;
      p_r         <= '0;
      q_r         <= '0;
      v_r         <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tick_r      <= tick_nxt;
      sl_r        <= sl_nxt;
      await_r     <= await_nxt;
      fslot_r     <= fslot_nxt;
      rearm_r     <= rearm_nxt;
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      v_r         <= v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    rep_r        <= rep_nxt;
    best_dl_r    <= best_dl_nxt;
    best_slot_r  <= best_slot_nxt;
    best_id_r    <= best_id_nxt;
    diff_small_r <= diff_small_nxt;
    diff16_r     <= diff16_nxt;
    due_r        <= due_nxt;
    bd63_r       <= bd63_nxt;
    ns_r         <= ns_nxt;
    fire_r       <= fire_nxt;
    status_r     <= status_nxt;
    out_type_r   <= out_type_nxt;
    out_seg_r    <= out_seg_nxt;
    out_key_r    <= out_key_nxt;
    out_st_r     <= out_st_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(stes_pkg::EVENT_CAP))
    else $error("entry count above table size");

  a_wait_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(await_r) |-> out_valid_r && out_type_r == stes_pkg::RES_FIRED && out_last_r)
    else $error("wait set without a fired result");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_type_r == stes_pkg::RES_STATUS |-> out_last_r)
    else $error("status result not final");

  a_fired_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_type_r == stes_pkg::RES_FIRED |-> out_last_r)
    else $error("fired result not final");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench: command items against a predicted event schedule.
`timescale 1ns / 100ps
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PHASE_ITEMS    = 270;

  typedef struct {
    logic [1:0]  rtype;
    logic [15:0] seg;
    logic [15:0] key;
    logic [1:0]  status;
    logic [62:0] tick;
    logic        last;
  } sched_result_t;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = stes_pkg::KIND_ADD;
  logic [15:0] in_event_key = '0;
  logic [31:0] in_delay = '0;
  logic [15:0] in_sample_count = '0;
  logic [31:0] in_repeat_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_type;
  logic [15:0] out_segment_length;
  logic [15:0] out_fired_key;
  logic [1:0]  out_status;
  logic [62:0] out_tick_now;
  logic        out_last;

  logic [63:0]   sched_deadline [stes_pkg::EVENT_SLOTS];
  logic [15:0]   sched_key [stes_pkg::EVENT_SLOTS];
  int            sched_count = 0;
  logic [62:0]   sched_tick = '0;
  int unsigned   sched_left = 0;
  bit            sched_waiting = 1'b0;
  int            sched_fired = 0;
  sched_result_t staged_results[$];
  sched_result_t pending_results[$];
  sched_result_t oldest_result;

  int          failures = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          sender_idle = 1'b1;
  bit          hold_off = 1'b0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          ready_phase = 0;

  sample_timed_event_scheduler_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_event_key       (in_event_key),
    .in_delay           (in_delay),
    .in_sample_count    (in_sample_count),
    .in_repeat_req      (in_repeat_req),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_type    (out_result_type),
    .out_segment_length (out_segment_length),
    .out_fired_key      (out_fired_key),
    .out_status         (out_status),
    .out_tick_now       (out_tick_now),
    .out_last           (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void stage(logic [1:0] rtype, logic [15:0] seg, logic [15:0] key,
                                logic [1:0] status);
    sched_result_t r;
    r.rtype  = rtype;
    r.seg    = seg;
    r.key    = key;
    r.status = status;
    r.tick   = sched_tick;
    r.last   = 1'b0;
    staged_results.push_back(r);
  endfunction

  function automatic int find_entry(logic [15:0] key);
    for (int i = 0; i < sched_count; i++) begin
      if (sched_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int slot);
    for (int j = slot; j < sched_count - 1; j++) begin
      sched_deadline[j] = sched_deadline[j + 1];
      sched_key[j]      = sched_key[j + 1];
    end
    sched_count--;
  endfunction

  function automatic void run_samples();
    int          best;
    bit          found;
    logic [63:0] span;
    logic [63:0] tick_wide;
    if (sched_left == 0) begin
      stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_OK);
      return;
    end
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < sched_count; i++) begin
      if (!found || sched_deadline[i] < sched_deadline[best]) begin
        best  = i;
        found = 1'b1;
      end
    end
    tick_wide = {1'b0, sched_tick};
    span      = 64'(sched_left);
    if (found) begin
      if (sched_deadline[best] <= tick_wide) span = '0;
      else if (sched_deadline[best] - tick_wide < span) span = sched_deadline[best] - tick_wide;
    end
    if (span != 0) begin
      sched_tick = sched_tick + span[62:0];
      sched_left = sched_left - 32'(span);
      stage(stes_pkg::RES_SEGMENT, span[15:0], 16'd0, stes_pkg::ST_OK);
    end
    if (found && sched_deadline[best] <= {1'b0, sched_tick}) begin
      sched_waiting = 1'b1;
      sched_fired   = best;
      stage(stes_pkg::RES_FIRED, 16'd0, sched_key[best], stes_pkg::ST_OK);
    end
  endfunction

  function automatic void schedule_command(logic [1:0] kind, logic [15:0] key,
                                           logic [31:0] delay, logic [15:0] count,
                                           logic [31:0] rep);
    int          slot;
    logic [64:0] grown;
    staged_results.delete();
    case (kind)
      stes_pkg::KIND_ADD: begin
        if (sched_count >= stes_pkg::EVENT_CAP) begin
          stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_FULL);
        end else begin
          sched_deadline[sched_count] = {1'b0, sched_tick} + 64'(delay);
          sched_key[sched_count]      = key;
          sched_count++;
          stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_OK);
        end
      end
      stes_pkg::KIND_REMOVE: begin
        if (sched_waiting) begin
          stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_WAITING);
        end else begin
          slot = find_entry(key);
          if (slot >= 0) begin
            drop_entry(slot);
            stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_OK);
          end else begin
            stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_NOTFOUND);
          end
        end
      end
      stes_pkg::KIND_ADVANCE: begin
        if (sched_waiting) begin
          stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_WAITING);
        end else begin
          sched_left = count;
          run_samples();
        end
      end
      default: begin
        if (!sched_waiting) begin
          stage(stes_pkg::RES_STATUS, 16'd0, 16'd0, stes_pkg::ST_WAITING);
        end else begin
          if (sched_fired < sched_count) begin
            if (rep != 0) begin
              grown = {1'b0, sched_deadline[sched_fired]} + 65'(rep);
              sched_deadline[sched_fired] = grown[64] ? '1 : grown[63:0];
            end else begin
              slot = find_entry(sched_key[sched_fired]);
              if (slot >= 0) drop_entry(slot);
            end
          end
          sched_waiting = 1'b0;
          run_samples();
        end
      end
    endcase
    staged_results[staged_results.size() - 1].last = 1'b1;
    foreach (staged_results[i]) pending_results.push_back(staged_results[i]);
  endfunction

  task automatic check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      failures++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t unexpected item: expected none actual type %0d tick %0d", $time,
                 out_result_type, out_tick_now);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("result_type", oldest_result.rtype, out_result_type);
        check_field("segment_length", oldest_result.seg, out_segment_length);
        check_field("fired_key", oldest_result.key, out_fired_key);
        check_field("status", oldest_result.status, out_status);
        check_field("tick_now", oldest_result.tick, out_tick_now);
        check_field("last", oldest_result.last, out_last);
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      ready_phase++;
      case (ready_mode)
        READY_ALWAYS:   out_ready <= 1'b1;
        READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
        READY_RARELY:   out_ready <= ($urandom_range(0, 3) == 0);
        READY_PERIODIC: out_ready <= (ready_phase % 5 != 0);
        default:        out_ready <= 1'b1;
      endcase
    end
  end

  task automatic send_item(logic [1:0] kind, logic [15:0] key, logic [31:0] delay,
                           logic [15:0] count, logic [31:0] rep);
    in_valid        <= 1'b1;
    sender_idle     = 1'b0;
    in_kind         <= kind;
    in_event_key    <= key;
    in_delay        <= delay;
    in_sample_count <= count;
    in_repeat_req   <= rep;
    do @(posedge clk); while (!in_ready);
    schedule_command(kind, key, delay, count, rep);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid    <= 1'b0;
      sender_idle = 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic await_idle();
    if (!sender_idle) begin
      in_valid    <= 1'b0;
      sender_idle = 1'b1;
    end
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 20) return 32'd0;
    return $urandom_range(1, 400);
  endfunction

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 18) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 600));
  endfunction

  function automatic logic [31:0] pick_repeat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'd0;
    if (r < 33) return $urandom;
    return $urandom_range(1, 400);
  endfunction

  task automatic send_random_op();
    int          r;
    logic [1:0]  kind;
    logic [15:0] key;
    r   = $urandom_range(0, 99);
    key = 16'($urandom);
    if (sched_waiting) begin
      if (r < 85) kind = stes_pkg::KIND_REARM;
      else if (r < 92) kind = stes_pkg::KIND_ADD;
      else if (r < 96) kind = stes_pkg::KIND_REMOVE;
      else kind = stes_pkg::KIND_ADVANCE;
    end else begin
      if (r < 38) kind = stes_pkg::KIND_ADD;
      else if (r < 58) kind = stes_pkg::KIND_REMOVE;
      else if (r < 95) kind = stes_pkg::KIND_ADVANCE;
      else kind = stes_pkg::KIND_REARM;
    end
    if (kind == stes_pkg::KIND_ADD && $urandom_range(0, 1) == 0) begin
      key = 16'($urandom_range(0, 15));
    end
    if (kind == stes_pkg::KIND_REMOVE && sched_count > 0 && $urandom_range(0, 3) != 0) begin
      key = sched_key[$urandom_range(0, sched_count - 1)];
    end
    send_item(kind, key, pick_delay(), pick_count(), pick_repeat());
  endtask

  task automatic test_idle_commands();
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'hFFFF, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(stes_pkg::KIND_REMOVE, 16'hFFFF, 32'd0, 16'd0, 32'd0);
  endtask

  task automatic test_fire_and_rearm();
    send_item(stes_pkg::KIND_ADD, 16'hFFFF, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADD, 16'h0000, 32'd10, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'd20, 32'd0);
    send_item(stes_pkg::KIND_ADD, 16'h1234, 32'd10, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REMOVE, 16'h0000, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'd5, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADD, 16'hABCD, 32'd7, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'd7, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REMOVE, 16'h0000, 32'd0, 16'd0, 32'd0);
  endtask

  task automatic test_duplicate_keys();
    send_item(stes_pkg::KIND_ADD, 16'h0005, 32'd100, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADD, 16'h0005, 32'd3, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_ADVANCE, 16'd0, 32'd0, 16'd10, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REARM, 16'd0, 32'd0, 16'd0, 32'd0);
  endtask

  task automatic test_table_full();
    while (sched_count < stes_pkg::EVENT_CAP) begin
      send_item(stes_pkg::KIND_ADD, 16'(sched_count),
                (sched_count == 7) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 300)),
                16'd0, 32'd0);
    end
    send_item(stes_pkg::KIND_ADD, 16'h7777, 32'd1, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REMOVE, 16'(stes_pkg::EVENT_CAP - 1), 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REMOVE, 16'd0, 32'd0, 16'd0, 32'd0);
    send_item(stes_pkg::KIND_REMOVE, 16'h8000, 32'd0, 16'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    hold_off   = 1'b1;
    burst_left = 100;
    repeat (40) send_random_op();
  endtask

  task automatic test_random_traffic(int items);
    repeat (items) send_random_op();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_fire_and_rearm();
    test_duplicate_keys();
    test_table_full();
    test_backpressure();
    await_idle();
    test_random_traffic(PHASE_ITEMS);
    await_idle();
    test_random_traffic(PHASE_ITEMS);
    await_idle();
    test_random_traffic(PHASE_ITEMS);
    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
